>>> rtl/critical_path_scheduler_top_macros.svh
// ----------------------------------------------------------------------------
// critical_path_scheduler_top_macros
// Assertion macros for the critical path scheduler.
// ----------------------------------------------------------------------------
`ifndef CRITICAL_PATH_SCHEDULER_TOP_MACROS_SVH
`define CRITICAL_PATH_SCHEDULER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CPS_ASSERT_NORST(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CPS_ASSERT(name, clk, rst, prop, msg)
`define CPS_ASSERT_NORST(name, clk, prop, msg)
`endif
`endif

>>> rtl/cps_pkg.sv
// ----------------------------------------------------------------------------
// cps_pkg
// Shared types and constants for the critical path scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cps_pkg;
  localparam int MAX_TASKS = 32;
  localparam int IDX_W     = 5;
  localparam int CNT_W     = 6;
  localparam int DUR_W     = 12;
  localparam int TIME_W    = 17;

  typedef enum logic [1:0] {
    OP_DUR  = 2'd0,
    OP_EDGE = 2'd1,
    OP_RUN  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [CNT_W-1:0] task_index;
    logic [CNT_W-1:0] predecessor_index;
    logic [DUR_W-1:0] duration;
  } in_t;

  typedef struct packed {
    logic [CNT_W-1:0]  task_id;
    logic [TIME_W-1:0] earliest_start;
    logic [TIME_W-1:0] latest_start;
    logic              is_critical;
    logic              status;
    logic              last_result;
  } out_t;

  typedef struct packed {
    logic wr_dur;
    logic wr_edge;
    logic idx_clr;
    logic idx_top;
    logic idx_inc;
    logic idx_dec;
    logic deg_init;
    logic deg_step;
    logic kahn_step;
    logic fwd_init;
    logic fwd_load;
    logic fwd_sum;
    logic fwd_upd;
    logic bwd_init;
    logic bwd_load;
    logic bwd_ls;
    logic bwd_upd;
    logic out_step;
    logic err_out;
    logic clear;
  } ctl_t;

  typedef struct packed {
    logic idx_last;
    logic idx_zero;
    logic found;
    logic all_done;
  } sts_t;
endpackage
`default_nettype wire

>>> rtl/cps_ctrl.sv
// ----------------------------------------------------------------------------
// cps_ctrl
// Sequencer for load, levelling, forward, backward and output phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cps_ctrl (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [1:0]   opcode,
  input  wire cps_pkg::sts_t sts,
  output cps_pkg::ctl_t     ctl,
  output logic              busy
);
  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DEG  = 11'b00000000010,
    S_KAHN = 11'b00000000100,
    S_FWDA = 11'b00000001000,
    S_FWDB = 11'b00000010000,
    S_FWDC = 11'b00000100000,
    S_BWDA = 11'b00001000000,
    S_BWDB = 11'b00010000000,
    S_BWDC = 11'b00100000000,
    S_OUTP = 11'b01000000000,
    S_ERR  = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            cps_pkg::OP_DUR:  ctl.wr_dur = 1'b1;
            cps_pkg::OP_EDGE: ctl.wr_edge = 1'b1;
            cps_pkg::OP_RUN: begin
              ctl.deg_init = 1'b1;
              ctl.idx_clr  = 1'b1;
              state_next   = S_DEG;
            end
            default: ;
          endcase
        end
      end
      S_DEG: begin
        ctl.deg_step = 1'b1;
        if (sts.idx_last) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_KAHN;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_KAHN: begin
        if (sts.found) begin
          ctl.kahn_step = 1'b1;
          ctl.idx_inc   = 1'b1;
        end else if (sts.all_done) begin
          ctl.fwd_init = 1'b1;
          ctl.idx_clr  = 1'b1;
          state_next   = S_FWDA;
        end else begin
          state_next = S_ERR;
        end
      end
      S_FWDA: begin
        ctl.fwd_load = 1'b1;
        state_next   = S_FWDB;
      end
      S_FWDB: begin
        ctl.fwd_sum = 1'b1;
        state_next  = S_FWDC;
      end
      S_FWDC: begin
        ctl.fwd_upd = 1'b1;
        if (sts.idx_last) begin
          ctl.bwd_init = 1'b1;
          ctl.idx_top  = 1'b1;
          state_next   = S_BWDA;
        end else begin
          ctl.idx_inc = 1'b1;
          state_next  = S_FWDA;
        end
      end
      S_BWDA: begin
        ctl.bwd_load = 1'b1;
        state_next   = S_BWDB;
      end
      S_BWDB: begin
        ctl.bwd_ls = 1'b1;
        state_next = S_BWDC;
      end
      S_BWDC: begin
        ctl.bwd_upd = 1'b1;
        if (sts.idx_zero) begin
          ctl.idx_clr = 1'b1;
          state_next  = S_OUTP;
        end else begin
          ctl.idx_dec = 1'b1;
          state_next  = S_BWDA;
        end
      end
      S_OUTP: begin
        ctl.out_step = 1'b1;
        if (sts.idx_last) begin
          ctl.clear  = 1'b1;
          state_next = S_IDLE;
        end else begin
          ctl.idx_inc = 1'b1;
        end
      end
      S_ERR: begin
        ctl.err_out = 1'b1;
        ctl.clear   = 1'b1;
        state_next  = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/cps_datapath.sv
// ----------------------------------------------------------------------------
// cps_datapath
// Edge matrix, durations, per-task lanes and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cps_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [cps_pkg::CNT_W-1:0]   cfg_data,
  input  wire cps_pkg::in_t                item,
  input  wire cps_pkg::ctl_t               ctl,
  output cps_pkg::sts_t                    sts,
  output cps_pkg::out_t                    result,
  output logic                             result_strobe
);
  localparam int N  = cps_pkg::MAX_TASKS;
  localparam int IW = cps_pkg::IDX_W;
  localparam int CW = cps_pkg::CNT_W;
  localparam int TW = cps_pkg::TIME_W;
  localparam int DW = cps_pkg::DUR_W;

  logic [CW-1:0] task_count;
  logic [CW-1:0] n;
  logic [N-1:0]  mask;
  logic [N-1:0]  edges [N];
  logic [DW-1:0] dur   [N];
  logic [CW-1:0] indeg [N];
  logic [N-1:0]  done;
  logic [IW-1:0] order [N];
  logic [TW-1:0] es [N];
  logic [TW-1:0] lf [N];
  logic [TW-1:0] ls [N];
  logic [CW-1:0] idx;
  logic [IW-1:0] cur;
  logic [TW-1:0] sum;
  logic [TW-1:0] ls_val;
  logic [TW-1:0] finish;
  logic [TW-1:0] fin_upd;
  logic [N-1:0]  ready;
  logic [IW-1:0] pick;
  logic          task_ok, pred_ok;

  always_ff @(posedge clk) begin
    if (rst)         task_count <= CW'(1);
    else if (cfg_we) task_count <= cfg_data;
  end

  always_comb begin
    if (task_count == '0)          n = CW'(1);
    else if (task_count > CW'(N))  n = CW'(N);
    else                           n = task_count;
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      mask[i]  = (CW'(i) < n);
      ready[i] = mask[i] && !done[i] && (indeg[i] == '0);
    end
    pick = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (ready[i]) pick = IW'(i);
    end
  end

  assign task_ok = (item.task_index != '0) && (item.task_index <= CW'(N));
  assign pred_ok = (item.predecessor_index != '0) && (item.predecessor_index <= CW'(N));

  assign sts.idx_last = (idx == n - CW'(1));
  assign sts.idx_zero = (idx == '0);
  assign sts.found    = |ready;
  assign sts.all_done = (idx == n);

  // edge store, cleared at reset and after every run
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      for (int i = 0; i < N; i++) edges[i] <= '0;
    end else if (ctl.wr_edge && task_ok && pred_ok) begin
      edges[IW'(item.predecessor_index - CW'(1))][IW'(item.task_index - CW'(1))] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_dur && task_ok) dur[IW'(item.task_index - CW'(1))] <= item.duration;
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.idx_clr) idx <= '0;
    else if (ctl.idx_top)   idx <= n - CW'(1);
    else if (ctl.idx_inc)   idx <= idx + CW'(1);
    else if (ctl.idx_dec)   idx <= idx - CW'(1);
  end

  // in-degree lanes and Kahn ordering
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= '0;
    end else if (ctl.deg_init) begin
      done <= '0;
    end else if (ctl.kahn_step) begin
      done[pick] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ctl.deg_init) begin
        indeg[i] <= '0;
      end else if (ctl.deg_step) begin
        indeg[i] <= indeg[i] + CW'(edges[idx[IW-1:0]][i] & mask[i]);
      end else if (ctl.kahn_step && edges[pick][i] && mask[i]) begin
        indeg[i] <= indeg[i] - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.kahn_step) order[idx[IW-1:0]] <= pick;
  end

  always_ff @(posedge clk) begin
    if (ctl.fwd_load || ctl.bwd_load) cur <= order[idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.fwd_sum) sum <= es[cur] + TW'(dur[cur]);
  end

  assign fin_upd = (ctl.fwd_upd && sum > finish) ? sum : finish;

  always_ff @(posedge clk) begin
    if (ctl.fwd_init)     finish <= '0;
    else if (ctl.fwd_upd) finish <= fin_upd;
  end

  // forward pass pushes finish of cur into its successors
  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ctl.fwd_init) begin
        es[i] <= '0;
      end else if (ctl.fwd_upd && edges[cur][i] && mask[i] && sum > es[i]) begin
        es[i] <= sum;
      end
    end
  end

  // backward pass pulls latest start of cur into its predecessors
  always_ff @(posedge clk) begin
    if (ctl.bwd_ls) begin
      ls_val  <= lf[cur] - TW'(dur[cur]);
      ls[cur] <= lf[cur] - TW'(dur[cur]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N; i++) begin
      if (ctl.bwd_init) begin
        lf[i] <= fin_upd;
      end else if (ctl.bwd_upd && edges[i][cur] && mask[i] && ls_val < lf[i]) begin
        lf[i] <= ls_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_strobe <= 1'b0;
    else     result_strobe <= ctl.out_step || ctl.err_out;
  end

  always_ff @(posedge clk) begin
    if (ctl.err_out) begin
      result <= '{task_id: '0, earliest_start: '0, latest_start: '0,
                  is_critical: 1'b0, status: 1'b1, last_result: 1'b1};
    end else if (ctl.out_step) begin
      result.task_id        <= idx + CW'(1);
      result.earliest_start <= es[idx[IW-1:0]];
      result.latest_start   <= ls[idx[IW-1:0]];
      result.is_critical    <= (es[idx[IW-1:0]] == ls[idx[IW-1:0]]);
      result.status         <= 1'b0;
      result.last_result    <= sts.idx_last;
    end
  end
endmodule
`default_nettype wire

>>> rtl/critical_path_scheduler_top.sv
// ----------------------------------------------------------------------------
// critical_path_scheduler_top
// Critical path method engine: graph load, Kahn ordering, forward and
// backward passes, one result per task (one error result for a cyclic graph).
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start & !busy           item (opcode, indices, duration)
//  result    result_strobe (1 cyc)   result (times, flags, status)
//  config    cfg_we                  cfg_data (task_count)
//
// Load transactions (duration, edge) are taken in idle; busy stays low.
// A run keeps busy high through the row sweep, the Kahn picks (one per cycle)
// plus the final check, the forward pass (load, sum, update per task), the
// backward pass (load, latest start, update per task) and the output sweep;
// each result is registered from its output step, so the last result is
// strobed in the cycle after busy drops.
// A cyclic graph stops at the first Kahn check that finds no ready task and
// ends with one error result in the cycle after busy drops.
// rst is synchronous; it clears the edge store and sets task_count to 1.
// Results are strobed one per cycle and cannot be held off.
`timescale 1ns / 1ps
`default_nettype none
`include "critical_path_scheduler_top_macros.svh"
module critical_path_scheduler_top (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  output logic                            busy,
  input  wire cps_pkg::in_t               item,
  input  wire logic                       cfg_we,
  input  wire logic [cps_pkg::CNT_W-1:0]  cfg_data,
  output logic                            result_strobe,
  output cps_pkg::out_t                   result
);
  cps_pkg::ctl_t ctl;
  cps_pkg::sts_t sts;

  // sequencer: issues one command set per cycle
  cps_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (item.opcode),
    .sts    (sts),
    .ctl    (ctl),
    .busy   (busy)
  );

  // storage and per-task lanes
  cps_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .item          (item),
    .ctl           (ctl),
    .sts           (sts),
    .result        (result),
    .result_strobe (result_strobe)
  );

  // error transaction is always the final one of its run
  `CPS_ASSERT(a_err_last, clk, rst, result_strobe && result.status |-> result.last_result, "error result without last flag")
  // nothing follows the final result of a run
  `CPS_ASSERT(a_last_gap, clk, rst, result_strobe && result.last_result |=> !result_strobe, "result after last")
  // a run transaction makes the block busy
  `CPS_ASSERT(a_run_busy, clk, rst, start && !busy && item.opcode == cps_pkg::OP_RUN |=> busy, "run not started")
  // good results name a real task
  `CPS_ASSERT(a_task_id, clk, rst, result_strobe && !result.status |-> result.task_id != '0, "zero task id")
endmodule
`default_nettype wire
